>>> rtl/tlga_pkg.sv
// ----------------------------------------------------------------------------
// tlga_pkg: shared types and codes for the two-level group arbiter
// Word layouts, command and status codes, sequencer states, memory ports.
// ----------------------------------------------------------------------------
package tlga_pkg;

  localparam int NUM_GROUPS = 16;
  localparam int ELEM_SLOTS = 64;
  localparam int GW         = $clog2(NUM_GROUPS);
  localparam int EW         = $clog2(ELEM_SLOTS);
  localparam int LW         = $clog2(ELEM_SLOTS + 1);

  typedef logic [GW-1:0] grp_t;
  typedef logic [EW-1:0] elem_t;

  // commands
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [2:0] CMD_SCHED     = 3'd2;
  localparam logic [2:0] CMD_DESCHED   = 3'd3;
  localparam logic [2:0] CMD_DISPATCH  = 3'd4;

  // dispatch results
  localparam logic [2:0] DC_REMOVE  = 3'd0;
  localparam logic [2:0] DC_NEXT    = 3'd1;
  localparam logic [2:0] DC_RESCHED = 3'd2;
  localparam logic [2:0] DC_DESCHED = 3'd3;
  localparam logic [2:0] DC_STOP    = 3'd4;

  // status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    grp_t       group_id;
    elem_t      elem_id;
    logic [2:0] dispatch_code;
  } word_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        done_valid;
    elem_t       done_elem;
    grp_t        done_group;
    logic        next_valid;
    elem_t       next_elem;
    grp_t        next_group;
    logic [LW-1:0] group_count;
    logic        group_scheduled;
  } word_out_t;

  // head/tail of a singly linked group list
  typedef struct packed {
    grp_t head;
    grp_t tail;
    logic any;
  } glist_t;

  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_RING,
    AFT_DEFER
  } after_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_RT,
    S_PUSH_RN,
    S_PUSH_W2,
    S_DESC_START,
    S_DESC_POP,
    S_DESC_WALK,
    S_DESC_CMP,
    S_DESC_LINK,
    S_DISP_RT,
    S_DISP_RH,
    S_DISP_RN,
    S_POP,
    S_POP_RD,
    S_AFTER,
    S_POST,
    S_NEXT_RT,
    S_NEXT_RE,
    S_OUT
  } state_t;

  // memory ports
  typedef struct packed {
    logic  we;
    elem_t waddr;
    elem_t wdata;
    elem_t raddr;
  } enext_req_t;

  typedef struct packed {
    logic  we;
    grp_t  waddr;
    elem_t wdata;
    grp_t  raddr;
  } gtail_req_t;

  typedef struct packed {
    logic we;
    grp_t waddr;
    grp_t wdata;
    grp_t raddr;
  } rnext_req_t;

  typedef struct packed {
    elem_t enext;
    elem_t gtail;
    grp_t  rnext;
  } mem_rd_t;

endpackage

>>> rtl/tlga_mem.sv
// ----------------------------------------------------------------------------
// tlga_mem: link storage of the arbiter
// Element links, group tails and group-list links; one write and one
// registered read per memory per cycle.
// ----------------------------------------------------------------------------
module tlga_mem import tlga_pkg::*; (
  input  logic       clk,
  input  enext_req_t enext_req,
  input  gtail_req_t gtail_req,
  input  rnext_req_t rnext_req,
  output mem_rd_t    rd
);

  elem_t elem_next  [ELEM_SLOTS];
  elem_t group_tail [NUM_GROUPS];
  grp_t  ring_next  [NUM_GROUPS];

  elem_t enext_rd;
  elem_t gtail_rd;
  grp_t  rnext_rd;

  assign rd = '{enext: enext_rd, gtail: gtail_rd, rnext: rnext_rd};

  always_ff @(posedge clk) begin
    if (enext_req.we) begin
      elem_next[enext_req.waddr] <= enext_req.wdata;
    end
    enext_rd <= elem_next[enext_req.raddr];
  end

  always_ff @(posedge clk) begin
    if (gtail_req.we) begin
      group_tail[gtail_req.waddr] <= gtail_req.wdata;
    end
    gtail_rd <= group_tail[gtail_req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rnext_req.we) begin
      ring_next[rnext_req.waddr] <= rnext_req.wdata;
    end
    rnext_rd <= ring_next[rnext_req.raddr];
  end

endmodule

>>> rtl/two_level_group_arbiter.sv
// ----------------------------------------------------------------------------
// two_level_group_arbiter: two-level round-robin scheduler
// Per-group element queues kept as circular linked lists, a ring of groups
// and a deferred list, all linked through small synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken on req when start is high and busy is low.
//   busy stays high while the sequencer walks the link memories; one result
//   word per command appears on rsp for one cycle with done high.
//   A bad code, a schedule or a push into an empty group takes only decode,
//   post and the output states; a push behind an existing tail adds a tail
//   read, a link read and a write; a dispatch reads the ring head's tail and
//   its head element (a group rotation adds a ring pop and a relink); a
//   deschedule walks the ring and then the deferred list link by link.
//   Each link step is one registered read of a link memory. A new command
//   can be accepted in the cycle its result is shown, so one command
//   occupies the block until its result is shown.
//   quota is written with cfg_we/cfg_wdata; the user must do so only while idle (the block does not enforce it).
//   Reset empties all groups, the ring and the deferred list, sets the quota
//   to 1. Link memories need no clearing: an entry is always written before
//   it is read. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module two_level_group_arbiter import tlga_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  word_in_t  req,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic      done,
  output word_out_t rsp
);

  state_t state, state_next;

  word_in_t rq;
  glist_t   ring, defr, lcur;
  logic [7:0] turn, quota, tinc;
  logic [ELEM_SLOTS-1:0] ebusy;
  logic [LW-1:0]         glen [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] gflag;
  logic [1:0] status_r;
  logic       dv;
  elem_t      de;
  grp_t       dg;
  grp_t       addr_r;
  logic       lsel;     // 0: walking the ring, 1: the deferred list
  grp_t       prev;
  after_t     after;
  elem_t      tail_r;

  enext_req_t enext_req;
  gtail_req_t gtail_req;
  rnext_req_t rnext_req;
  mem_rd_t    rd;

  grp_t  g;
  elem_t e;
  logic  is_push, bad;
  glist_t lafter;

  assign g       = rq.group_id;
  assign e       = rq.elem_id;
  assign is_push = (rq.command == CMD_PUSH_TAIL) || (rq.command == CMD_PUSH_HEAD);
  assign bad     = (rq.command > CMD_DISPATCH) ||
                   ((rq.command == CMD_DISPATCH) && (rq.dispatch_code > DC_STOP));
  assign lcur    = lsel ? defr : ring;
  assign lafter  = (after == AFT_DEFER) ? defr : ring;
  assign tinc    = (turn != 8'hFF) ? turn + 8'd1 : turn;
  assign busy    = (state != S_IDLE);

  tlga_mem u_mem (
    .clk       (clk),
    .enext_req (enext_req),
    .gtail_req (gtail_req),
    .rnext_req (rnext_req),
    .rd        (rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_POST;
        if (!bad) begin
          if (is_push) begin
            if (!ebusy[e] && glen[g] != '0) state_next = S_PUSH_RT;
          end else if (rq.command == CMD_DESCHED) begin
            if (glen[g] != '0 && gflag[g]) state_next = S_DESC_START;
          end else if (rq.command == CMD_DISPATCH) begin
            if (ring.any) state_next = S_DISP_RT;
          end
        end
      end
      S_PUSH_RT: state_next = S_PUSH_RN;
      S_PUSH_RN: state_next = S_PUSH_W2;
      S_PUSH_W2: state_next = S_POST;
      S_DESC_START: begin
        if (!lcur.any) begin
          state_next = lsel ? S_POST : S_DESC_START;
        end else if (lcur.head == g) begin
          state_next = (lcur.head == lcur.tail) ? S_POST : S_DESC_POP;
        end else begin
          state_next = S_DESC_WALK;
        end
      end
      S_DESC_POP: state_next = S_POST;
      S_DESC_WALK: begin
        if (prev == lcur.tail) state_next = lsel ? S_POST : S_DESC_START;
        else                   state_next = S_DESC_CMP;
      end
      S_DESC_CMP: begin
        if (rd.rnext == g) state_next = (lcur.tail == g) ? S_POST : S_DESC_LINK;
        else               state_next = S_DESC_WALK;
      end
      S_DESC_LINK: state_next = S_POST;
      S_DISP_RT:   state_next = S_DISP_RH;
      S_DISP_RH: begin
        if (rq.dispatch_code == DC_REMOVE) begin
          state_next = (glen[dg] <= LW'(1)) ? S_POP : S_DISP_RN;
        end else if (rq.dispatch_code == DC_STOP) begin
          state_next = S_POST;
        end else begin
          state_next = S_POP;
        end
      end
      S_DISP_RN: state_next = (tinc >= quota) ? S_POP : S_POST;
      S_POP:     state_next = (ring.head == ring.tail) ? S_AFTER : S_POP_RD;
      S_POP_RD:  state_next = S_AFTER;
      S_AFTER:   state_next = S_POST;
      S_POST:    state_next = S_NEXT_RT;
      S_NEXT_RT: state_next = S_NEXT_RE;
      S_NEXT_RE: state_next = S_OUT;
      S_OUT:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    gtail_req       = '0;
    gtail_req.raddr = (state == S_DECODE && is_push) ? g : ring.head;
    enext_req       = '0;
    enext_req.raddr = (state == S_DISP_RH) ? rd.enext : rd.gtail;
    rnext_req       = '0;
    rnext_req.raddr = ring.head;
    unique case (state)
      S_DECODE: begin
        // first element of an empty group links to itself
        if (!bad && is_push && !ebusy[e] && glen[g] == '0) begin
          gtail_req.we    = 1'b1;
          gtail_req.waddr = g;
          gtail_req.wdata = e;
          enext_req.we    = 1'b1;
          enext_req.waddr = e;
          enext_req.wdata = e;
        end
        if (!bad && rq.command == CMD_SCHED && glen[g] != '0 && !gflag[g] && ring.any) begin
          rnext_req.we    = 1'b1;
          rnext_req.waddr = ring.tail;
          rnext_req.wdata = g;
        end
      end
      S_PUSH_RN: begin
        enext_req.we    = 1'b1;
        enext_req.waddr = e;
        enext_req.wdata = rd.enext;
      end
      S_PUSH_W2: begin
        enext_req.we    = 1'b1;
        enext_req.waddr = tail_r;
        enext_req.wdata = e;
        gtail_req.we    = (rq.command == CMD_PUSH_TAIL);
        gtail_req.waddr = g;
        gtail_req.wdata = e;
      end
      S_DESC_START: rnext_req.raddr = lcur.head;
      S_DESC_WALK:  rnext_req.raddr = prev;
      S_DESC_CMP:   rnext_req.raddr = g;
      S_DESC_LINK: begin
        rnext_req.we    = 1'b1;
        rnext_req.waddr = prev;
        rnext_req.wdata = rd.rnext;
      end
      S_DISP_RH: begin
        // stop: deferred list joins the ring tail
        if (rq.dispatch_code == DC_STOP && defr.any) begin
          rnext_req.we    = 1'b1;
          rnext_req.waddr = ring.tail;
          rnext_req.wdata = defr.head;
        end
      end
      S_DISP_RN: begin
        enext_req.we    = 1'b1;
        enext_req.waddr = tail_r;
        enext_req.wdata = rd.enext;
      end
      S_AFTER: begin
        if (after != AFT_NONE && lafter.any) begin
          rnext_req.we    = 1'b1;
          rnext_req.waddr = lafter.tail;
          rnext_req.wdata = dg;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring  <= '0;
      defr  <= '0;
      turn  <= '0;
      quota <= 8'd1;
      ebusy <= '0;
      gflag <= '0;
      done  <= 1'b0;
      lsel  <= 1'b0;
      after <= AFT_NONE;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        glen[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) quota <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (start) rq <= req;
        end
        S_DECODE: begin
          status_r <= ST_OK;
          dv       <= 1'b0;
          de       <= '0;
          dg       <= '0;
          addr_r   <= g;
          lsel     <= 1'b0;
          if (bad) begin
            status_r <= ST_BAD;
          end else if (is_push) begin
            if (ebusy[e]) begin
              status_r <= ST_DUP;
            end else if (glen[g] == '0) begin
              glen[g]  <= glen[g] + LW'(1);
              ebusy[e] <= 1'b1;
            end
          end else if (rq.command == CMD_SCHED) begin
            if (glen[g] == '0) begin
              status_r <= ST_EMPTY;
            end else if (!gflag[g]) begin
              if (!ring.any) begin
                turn      <= '0;
                ring.head <= g;
                ring.any  <= 1'b1;
              end
              ring.tail <= g;
              gflag[g]  <= 1'b1;
            end
          end else if (rq.command == CMD_DESCHED) begin
            if (glen[g] == '0) begin
              status_r <= ST_EMPTY;
            end else if (gflag[g]) begin
              if (ring.any && ring.head == g) turn <= '0;
              gflag[g] <= 1'b0;
            end
          end else begin
            if (!ring.any) begin
              status_r <= ST_EMPTY;
            end else begin
              dv     <= 1'b1;
              dg     <= ring.head;
              addr_r <= ring.head;
            end
          end
        end
        S_PUSH_RT: tail_r <= rd.gtail;
        S_PUSH_W2: begin
          glen[g]  <= glen[g] + LW'(1);
          ebusy[e] <= 1'b1;
        end
        S_DESC_START: begin
          if (!lcur.any) begin
            lsel <= 1'b1;
          end else if (lcur.head == g) begin
            if (lcur.head == lcur.tail) begin
              if (lsel) defr.any <= 1'b0;
              else      ring.any <= 1'b0;
            end
          end else begin
            prev <= lcur.head;
          end
        end
        S_DESC_POP: begin
          if (lsel) defr.head <= rd.rnext;
          else      ring.head <= rd.rnext;
        end
        S_DESC_WALK: begin
          if (prev == lcur.tail) lsel <= 1'b1;
        end
        S_DESC_CMP: begin
          if (rd.rnext == g) begin
            if (lcur.tail == g) begin
              if (lsel) defr.tail <= prev;
              else      ring.tail <= prev;
            end
          end else begin
            prev <= rd.rnext;
          end
        end
        S_DISP_RT: tail_r <= rd.gtail;
        S_DISP_RH: begin
          de    <= rd.enext;
          after <= AFT_NONE;
          if (rq.dispatch_code == DC_REMOVE) begin
            ebusy[rd.enext] <= 1'b0;
            if (glen[dg] <= LW'(1)) begin
              glen[dg]  <= '0;
              gflag[dg] <= 1'b0;
              turn      <= '0;
            end
          end else begin
            turn <= '0;
            if (rq.dispatch_code == DC_NEXT)    after <= AFT_RING;
            if (rq.dispatch_code == DC_RESCHED) after <= AFT_DEFER;
            if (rq.dispatch_code == DC_DESCHED) gflag[dg] <= 1'b0;
            if (rq.dispatch_code == DC_STOP && defr.any) begin
              ring.tail <= defr.tail;
              defr.any  <= 1'b0;
            end
          end
        end
        S_DISP_RN: begin
          glen[dg] <= glen[dg] - LW'(1);
          if (tinc >= quota) begin
            turn  <= '0;
            after <= AFT_RING;
          end else begin
            turn <= tinc;
          end
        end
        S_POP: begin
          if (ring.head == ring.tail) ring.any <= 1'b0;
        end
        S_POP_RD: ring.head <= rd.rnext;
        S_AFTER: begin
          if (after == AFT_RING) begin
            if (!ring.any) begin
              ring.head <= dg;
              ring.any  <= 1'b1;
            end
            ring.tail <= dg;
          end else if (after == AFT_DEFER) begin
            if (!defr.any) begin
              defr.head <= dg;
              defr.any  <= 1'b1;
            end
            defr.tail <= dg;
          end
        end
        S_POST: begin
          // empty ring takes over the deferred list
          if (!ring.any && defr.any) begin
            ring     <= defr;
            turn     <= '0;
            defr.any <= 1'b0;
          end
        end
        S_OUT: begin
          done                <= 1'b1;
          rsp.status          <= status_r;
          rsp.done_valid      <= dv;
          rsp.done_elem       <= de;
          rsp.done_group      <= dg;
          rsp.next_valid      <= ring.any;
          rsp.next_elem       <= ring.any ? rd.enext : '0;
          rsp.next_group      <= ring.any ? ring.head : '0;
          rsp.group_count     <= glen[addr_r];
          rsp.group_scheduled <= (glen[addr_r] != '0) && gflag[addr_r];
        end
        default: ;
      endcase
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");
  a_dv_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.done_valid) |-> (rsp.status == ST_OK))
    else $error("dispatch applied with error status");
  a_rejoin: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (ring.any || !defr.any))
    else $error("deferred groups left behind an empty ring");

endmodule
